// ===== hw/rtl/fcser_pkg.sv =====
package fcser_pkg;

  localparam int unsigned BITS_PER_FRAME = 12;
  localparam int unsigned NUM_CHANNELS   = 4;
  localparam int unsigned POS_W          = 12;
  localparam int unsigned PIN_W          = 4;
  localparam int unsigned GAP_W          = 16;
  localparam int unsigned BIT_IDX_W      = 4;

  localparam logic [GAP_W-1:0]     GAP_LIMIT_RESET = 16'd100;
  localparam logic [GAP_W-1:0]     GAP_COUNT_MAX   = 16'hFFFF;
  localparam logic [BIT_IDX_W-1:0] LAST_BIT_IDX    = BIT_IDX_W'(BITS_PER_FRAME - 1);

  typedef logic [POS_W-1:0] pos_t;

  typedef enum logic [2:0] {
    PH_START   = 3'd0,
    PH_CLK_UP  = 3'd1,
    PH_SAMPLE  = 3'd2,
    PH_ACCUM   = 3'd3,
    PH_LATCH   = 3'd4
  } phase_e;

endpackage

// ===== hw/rtl/fcser_if.sv =====
interface fcser_in_if;
  import fcser_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIN_W-1:0] data_pins;

  modport source (output valid, output data_pins, input ready);
  modport sink   (input valid, input data_pins, output ready);
endinterface

interface fcser_out_if;
  import fcser_pkg::*;
  logic valid;
  logic ready;
  logic clock_level;
  pos_t position_ch0;
  pos_t position_ch1;
  pos_t position_ch2;
  pos_t position_ch3;
  logic frame_latched;

  modport source (output valid, output clock_level, output position_ch0,
                  output position_ch1, output position_ch2, output position_ch3,
                  output frame_latched, input ready);
  modport sink   (input valid, input clock_level, input position_ch0,
                  input position_ch1, input position_ch2, input position_ch3,
                  input frame_latched, output ready);
endinterface

// ===== hw/rtl/four_channel_serial_encoder_reader_unit.sv =====
// Four-channel serial absolute encoder reader (12-bit, shared clock line).
// in_i  : one beat per tick, carrying the four encoder data pin levels.
// out_o : one beat per input beat: clock line level, four latched positions
//         and a flag that marks ticks on which the latches were refreshed.
// cfg   : cfg_we_i/cfg_wdata_i write gap_limit (reset 100); write only idle.
// Each tick walks the frame sequencer one step: clear, clock up, then twelve
// sample / accumulate pairs, then a latch-and-gap phase of gap_limit+2 ticks.
// Latency: the result beat is valid the cycle after the input beat.
// Throughput: one beat per cycle while out_o.ready is high; all the work for
// a tick sits between the sequencer state registers and the output register.
// in_i.ready is high while the output register is empty or being drained,
// so a stalled receiver holds the result and stops intake after one beat.
// Reset clears the sequencer, accumulators, latches and the output valid;
// gap_limit returns to 100. No clearing pass is needed.
module four_channel_serial_encoder_reader_unit
  import fcser_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [GAP_W-1:0]  cfg_wdata_i,
  fcser_in_if.sink          in_i,
  fcser_out_if.source       out_o
);

  // sequencer state
  phase_e               phase_q, phase_d;
  logic [BIT_IDX_W-1:0] bit_idx_q, bit_idx_d;
  logic [GAP_W-1:0]     gap_cnt_q, gap_cnt_d;
  logic [PIN_W-1:0]     sampled_q, sampled_d;
  logic                 clk_out_q, clk_out_d;
  pos_t                 acc_q   [NUM_CHANNELS];
  pos_t                 acc_d   [NUM_CHANNELS];
  pos_t                 latch_q [NUM_CHANNELS];
  pos_t                 latch_d [NUM_CHANNELS];
  logic                 latched_d;
  logic [GAP_W-1:0]     gap_limit_q;

  // output register
  logic                 out_valid_q;
  logic                 out_clk_q;
  pos_t                 out_pos_q [NUM_CHANNELS];
  logic                 out_latched_q;

  logic                 accept;
  logic                 gap_done;
  pos_t                 weight;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  // gap ends past the limit, or at the saturation point
  assign gap_done = (gap_cnt_q > gap_limit_q) || (gap_cnt_q == GAP_COUNT_MAX);
  // MSB-first bit weight
  assign weight   = pos_t'(1) << (LAST_BIT_IDX - bit_idx_q);

  // next phase
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      PH_CLK_UP: phase_d = PH_SAMPLE;
      PH_SAMPLE: phase_d = PH_ACCUM;
      PH_ACCUM:  phase_d = (bit_idx_q == LAST_BIT_IDX) ? PH_LATCH : PH_SAMPLE;
      PH_LATCH:  phase_d = gap_done ? PH_START : PH_LATCH;
      default:   phase_d = PH_CLK_UP;
    endcase
  end

  // datapath per phase
  always_comb begin
    bit_idx_d = bit_idx_q;
    gap_cnt_d = gap_cnt_q;
    sampled_d = sampled_q;
    clk_out_d = clk_out_q;
    acc_d     = acc_q;
    latch_d   = latch_q;
    latched_d = 1'b0;
    unique case (phase_q)
      PH_CLK_UP: begin
        clk_out_d = 1'b1;
      end
      PH_SAMPLE: begin
        sampled_d = in_i.data_pins;
        clk_out_d = 1'b0;
      end
      PH_ACCUM: begin
        for (int c = 0; c < NUM_CHANNELS; c++) begin
          if (sampled_q[c]) acc_d[c] = acc_q[c] + weight;
        end
        clk_out_d = 1'b1;
        bit_idx_d = bit_idx_q + BIT_IDX_W'(1);
      end
      PH_LATCH: begin
        latch_d   = acc_q;
        latched_d = 1'b1;
        gap_cnt_d = gap_done ? '0 : gap_cnt_q + GAP_W'(1);
      end
      default: begin
        bit_idx_d = '0;
        clk_out_d = 1'b0;
        for (int c = 0; c < NUM_CHANNELS; c++) acc_d[c] = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_START;
      bit_idx_q   <= '0;
      gap_cnt_q   <= '0;
      sampled_q   <= '0;
      clk_out_q   <= 1'b0;
      out_valid_q <= 1'b0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        acc_q[c]   <= '0;
        latch_q[c] <= '0;
      end
    end else begin
      if (accept) begin
        phase_q   <= phase_d;
        bit_idx_q <= bit_idx_d;
        gap_cnt_q <= gap_cnt_d;
        sampled_q <= sampled_d;
        clk_out_q <= clk_out_d;
        acc_q     <= acc_d;
        latch_q   <= latch_d;
      end
      if (accept)            out_valid_q <= 1'b1;
      else if (out_o.ready)  out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_limit_q <= GAP_LIMIT_RESET;
    end else if (cfg_we_i) begin
      gap_limit_q <= cfg_wdata_i;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_clk_q     <= clk_out_d;
      out_pos_q     <= latch_d;
      out_latched_q <= latched_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.clock_level   = out_clk_q;
  assign out_o.position_ch0  = out_pos_q[0];
  assign out_o.position_ch1  = out_pos_q[1];
  assign out_o.position_ch2  = out_pos_q[2];
  assign out_o.position_ch3  = out_pos_q[3];
  assign out_o.frame_latched = out_latched_q;

endmodule

// ===== tb/sv/tb_four_channel_serial_encoder_reader_unit.sv =====
`timescale 1ns / 100ps

module tb_four_channel_serial_encoder_reader_unit;
  import fcser_pkg::*;

  // One output beat as the checker sees it.
  typedef struct packed {
    logic clock_level;
    pos_t position_ch0;
    pos_t position_ch1;
    pos_t position_ch2;
    pos_t position_ch3;
    logic frame_latched;
  } reader_beat_t;

  // Directed table row: pins to drive, and an expected beat when it is typed in.
  typedef struct packed {
    logic [PIN_W-1:0] pins;
    logic             typed;
    reader_beat_t     want;
  } table_row_t;

  localparam int unsigned RANDOM_ITEMS   = 200;
  localparam int unsigned LONG_GAP_ITEMS = 200;    // one 152-tick gap plus a restart
  localparam logic [GAP_W-1:0] LONG_GAP  = 16'd150;
  localparam int unsigned LONG_HOLD      = 64;     // receiver hold-off, well past one beat
  localparam int unsigned STALL_LIMIT    = 1000;   // cycles with no beat on either side
  localparam int unsigned FRAME_ROWS     = 28;

  localparam reader_beat_t BEAT_NONE   = '0;
  // Start tick: accumulators cleared, clock low, latches still at reset.
  localparam reader_beat_t BEAT_START  = '{default: '0};
  localparam reader_beat_t BEAT_CLK_UP = '{clock_level: 1'b1, default: '0};
  // Latch ticks of the directed frame: ch0 all ones, ch1 all zeros,
  // ch2 and ch3 alternating bits in opposite phase.
  localparam reader_beat_t BEAT_LATCH  = '{1'b1, 12'hFFF, 12'h000, 12'hAAA, 12'h555, 1'b1};

  // One frame at the reset gap setting, up to its first two latch ticks.
  // Sample ticks carry 5/9 (ch0 set, ch1 clear, ch2/ch3 toggling MSB first);
  // accumulate ticks carry the complement, which the block must ignore.
  localparam table_row_t FRAME_TABLE [FRAME_ROWS] = '{
    '{4'hF, 1'b1, BEAT_START},
    '{4'h0, 1'b1, BEAT_CLK_UP},
    '{4'h5, 1'b0, BEAT_NONE}, '{4'hA, 1'b0, BEAT_NONE},
    '{4'h9, 1'b0, BEAT_NONE}, '{4'h6, 1'b0, BEAT_NONE},
    '{4'h5, 1'b0, BEAT_NONE}, '{4'hA, 1'b0, BEAT_NONE},
    '{4'h9, 1'b0, BEAT_NONE}, '{4'h6, 1'b0, BEAT_NONE},
    '{4'h5, 1'b0, BEAT_NONE}, '{4'hA, 1'b0, BEAT_NONE},
    '{4'h9, 1'b0, BEAT_NONE}, '{4'h6, 1'b0, BEAT_NONE},
    '{4'h5, 1'b0, BEAT_NONE}, '{4'hA, 1'b0, BEAT_NONE},
    '{4'h9, 1'b0, BEAT_NONE}, '{4'h6, 1'b0, BEAT_NONE},
    '{4'h5, 1'b0, BEAT_NONE}, '{4'hA, 1'b0, BEAT_NONE},
    '{4'h9, 1'b0, BEAT_NONE}, '{4'h6, 1'b0, BEAT_NONE},
    '{4'h5, 1'b0, BEAT_NONE}, '{4'hA, 1'b0, BEAT_NONE},
    '{4'h9, 1'b0, BEAT_NONE}, '{4'h6, 1'b0, BEAT_NONE},
    '{4'h3, 1'b1, BEAT_LATCH},
    '{4'hC, 1'b1, BEAT_LATCH}
  };

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [GAP_W-1:0] cfg_wdata;

  fcser_in_if  in_bus ();
  fcser_out_if out_bus ();

  four_channel_serial_encoder_reader_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_bus),
    .out_o       (out_bus)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------
  // Frame sequencer predictor: own copy of the sequencer state and gap setting.
  // ---------------------------------------------------------------------
  phase_e               ph;
  logic [BIT_IDX_W-1:0] bit_idx;
  logic [GAP_W-1:0]     gap_cnt;
  logic [GAP_W-1:0]     gap_lim;
  logic [PIN_W-1:0]     sampled;
  pos_t                 acc  [NUM_CHANNELS];
  pos_t                 held [NUM_CHANNELS];
  logic                 clk_line;

  reader_beat_t expected_beats [$];

  int unsigned ticks_sent;
  int unsigned frames_begun;
  int unsigned latch_beats;
  int unsigned mismatches;
  int unsigned stall_cycles;
  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;
  int unsigned hold_token;
  int unsigned mid_gap;
  int unsigned last_gap;

  // Advance the predicted sequencer by one tick, return the beat it drives.
  function automatic reader_beat_t encoder_tick(logic [PIN_W-1:0] pins);
    reader_beat_t beat;
    logic         latch_now;
    int           c;
    latch_now = 1'b0;
    case (ph)
      PH_CLK_UP: begin
        clk_line = 1'b1;
        ph       = PH_SAMPLE;
      end
      PH_SAMPLE: begin
        sampled  = pins;
        clk_line = 1'b0;
        ph       = PH_ACCUM;
      end
      PH_ACCUM: begin
        // MSB first: weight of this bit is 2^(11 - index); 12-bit wrap.
        for (c = 0; c < NUM_CHANNELS; c++)
          if (sampled[c]) acc[c] = acc[c] + (pos_t'(1) << (LAST_BIT_IDX - bit_idx));
        clk_line = 1'b1;
        bit_idx  = bit_idx + BIT_IDX_W'(1);
        ph       = (bit_idx < BITS_PER_FRAME) ? PH_SAMPLE : PH_LATCH;
      end
      PH_LATCH: begin
        for (c = 0; c < NUM_CHANNELS; c++) held[c] = acc[c];
        latch_now = 1'b1;
        // Gap ends past the limit, or when the counter is pinned at full scale.
        if (gap_cnt > gap_lim || gap_cnt == GAP_COUNT_MAX) begin
          gap_cnt = '0;
          ph      = PH_START;
        end else begin
          gap_cnt = gap_cnt + GAP_W'(1);
        end
      end
      default: begin
        bit_idx  = '0;
        for (c = 0; c < NUM_CHANNELS; c++) acc[c] = '0;
        clk_line = 1'b0;
        ph       = PH_CLK_UP;
        frames_begun++;
      end
    endcase
    beat.clock_level   = clk_line;
    beat.position_ch0  = held[0];
    beat.position_ch1  = held[1];
    beat.position_ch2  = held[2];
    beat.position_ch3  = held[3];
    beat.frame_latched = latch_now;
    return beat;
  endfunction

  task automatic flag_mismatch(string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic check_field(string name, logic [POS_W-1:0] got, logic [POS_W-1:0] want);
    if (got !== want) flag_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  // ---------------------------------------------------------------------
  // Input side. Sender idles with probability src_idle_pct per cycle.
  // valid/ready are looked at right after the edge, i.e. pre-edge values.
  // ---------------------------------------------------------------------
  task automatic drive_tick(logic [PIN_W-1:0] pins, logic typed, reader_beat_t want);
    reader_beat_t predicted;
    while ($urandom_range(99) < src_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.data_pins <= pins;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    // Beat accepted at this edge: step the predictor, queue what comes back.
    predicted = encoder_tick(pins);
    ticks_sent++;
    expected_beats.push_back(typed ? want : predicted);
  endtask

  task automatic run_random(int unsigned n);
    repeat (n) drive_tick(PIN_W'($urandom_range(15)), 1'b0, BEAT_NONE);
  endtask

  // Sender stops and waits for every queued result; block goes idle.
  task automatic quiesce();
    in_bus.valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
  endtask

  // gap_limit may only change while idle. Result is registered behind its
  // input beat, so a wait after the drain covers the output register.
  task automatic write_gap_limit(logic [GAP_W-1:0] value);
    quiesce();
    repeat (2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    gap_lim    = value;
  endtask

  // ---------------------------------------------------------------------
  // Output side. Random stalls at snk_stall_pct; a bump of hold_token
  // starts one long hold-off so the output register fills and intake stops.
  // ---------------------------------------------------------------------
  initial begin : sink_ready
    int unsigned seen;
    int unsigned n;
    seen          = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_token != seen) begin
        seen = hold_token;
        for (n = 0; n < LONG_HOLD; n++) begin
          out_bus.ready <= 1'b0;
          @(posedge clk);
        end
      end
      out_bus.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Every accepted result beat against the oldest expectation.
  always @(posedge clk) begin : result_check
    reader_beat_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (expected_beats.size() == 0) begin
        flag_mismatch("result beat with nothing expected");
      end else begin
        want = expected_beats.pop_front();
        check_field("clock_level",   POS_W'(out_bus.clock_level),
                    POS_W'(want.clock_level));
        check_field("position_ch0",  out_bus.position_ch0,  want.position_ch0);
        check_field("position_ch1",  out_bus.position_ch1,  want.position_ch1);
        check_field("position_ch2",  out_bus.position_ch2,  want.position_ch2);
        check_field("position_ch3",  out_bus.position_ch3,  want.position_ch3);
        check_field("frame_latched", POS_W'(out_bus.frame_latched),
                    POS_W'(want.frame_latched));
        if (want.frame_latched) latch_beats++;
      end
    end
  end

  // Watchdog: no beat on either side for too long ends the run.
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_cycles <= 0;
    end else if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d results pending",
                 stall_cycles, expected_beats.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus sequence.
  // ---------------------------------------------------------------------
  initial begin : stimulus
    int r;
    clk              = 1'b0;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    in_bus.valid     = 1'b0;
    in_bus.data_pins = '0;
    src_idle_pct     = 0;
    snk_stall_pct    = 0;
    hold_token       = 0;
    ticks_sent       = 0;
    frames_begun     = 0;
    latch_beats      = 0;
    mismatches       = 0;

    // Predictor comes up as the block does after reset.
    ph       = PH_START;
    bit_idx  = '0;
    gap_cnt  = '0;
    gap_lim  = GAP_LIMIT_RESET;
    sampled  = '0;
    clk_line = 1'b0;
    for (r = 0; r < NUM_CHANNELS; r++) begin
      acc[r]  = '0;
      held[r] = '0;
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frame at the reset gap setting, then random ticks there so
    // the full 102-tick gap and the restart are seen.
    for (r = 0; r < FRAME_ROWS; r++)
      drive_tick(FRAME_TABLE[r].pins, FRAME_TABLE[r].typed, FRAME_TABLE[r].want);
    run_random(RANDOM_ITEMS);

    // Shortest gap, sender idle most of the time.
    write_gap_limit('0);
    src_idle_pct = 72;
    run_random(RANDOM_ITEMS);

    // Gap of three ticks, receiver stalling most of the time.
    write_gap_limit(16'd1);
    src_idle_pct   = 0;
    snk_stall_pct <= 72;
    run_random(RANDOM_ITEMS);

    // Mid-range gap, both sides idling lightly.
    mid_gap = $urandom_range(40, 2);
    write_gap_limit(GAP_W'(mid_gap));
    src_idle_pct   = 8;
    snk_stall_pct <= 8;
    run_random(RANDOM_ITEMS);

    // Back-pressure: receiver holds off while the sender keeps offering,
    // then the sender drains everything before carrying on.
    write_gap_limit('0);
    src_idle_pct   = 0;
    snk_stall_pct <= 0;
    run_random(40);
    hold_token <= hold_token + 1;
    run_random(120);
    quiesce();
    run_random(60);

    // Long gap: counter runs past 7 bits before the frame restarts.
    write_gap_limit(LONG_GAP);
    run_random(LONG_GAP_ITEMS);

    // Small random gap, no idling.
    last_gap = $urandom_range(15);
    write_gap_limit(GAP_W'(last_gap));
    run_random(RANDOM_ITEMS);

    // Drain, then wait so the block can show any stray beat.
    snk_stall_pct <= 0;
    quiesce();
    repeat (4) @(posedge clk);

    $display("Covered %0d ticks, %0d frame starts, %0d latch beats checked.",
             ticks_sent, frames_begun, latch_beats);
    $display("Gap settings: reset 100, 0, 1, %0d, 0 with hold-off, %0d, %0d.",
             mid_gap, LONG_GAP, last_gap);
    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches, %0d results never seen", mismatches, expected_beats.size());
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/fcser_pkg.sv
hw/rtl/fcser_if.sv
hw/rtl/four_channel_serial_encoder_reader_unit.sv
tb/sv/tb_four_channel_serial_encoder_reader_unit.sv
